FILE: src/assert_macros.svh
// assertion helpers shared by the checker files
// both macros expect signals named clk and rst_n in the calling scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the cycle after the trigger
`define PTC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("ptc check failed: next-cycle property");

// condition holds in the same cycle as the trigger
`define PTC_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("ptc check failed: same-cycle property");

`endif

FILE: src/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

  // field widths
  localparam int PIX_W      = 12;
  localparam int FAC_W      = 9;
  localparam int GAIN_W     = 16;
  localparam int POS_W      = 20;
  localparam int RATE_W     = 17;
  localparam int ERR_W      = 13;
  localparam int DIFF_W     = 21;
  localparam int MA_W       = 17;
  localparam int PROD_W     = MA_W + DIFF_W;
  localparam int TGT_W      = 9;
  localparam int OUT_W      = 9;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 5;
  localparam int SLOW_W     = 9;

  // controller constants
  localparam int MAX_DRIVE_RATE = 255;
  localparam int SLOW_SCALE_Q8  = 128;
  localparam int FAC_ONE        = 256;

  // register reset values
  localparam logic [FAC_W-1:0]  RST_POS_SMOOTH  = FAC_W'(77);
  localparam logic [FAC_W-1:0]  RST_RATE_SMOOTH = FAC_W'(64);
  localparam logic [PIX_W-1:0]  RST_DEADBAND    = PIX_W'(20);
  localparam logic [GAIN_W-1:0] RST_GAIN        = GAIN_W'(128);
  localparam logic [PIX_W-1:0]  RST_SLOW_ZONE   = PIX_W'(40);

  typedef enum logic [OP_W-1:0] {
    OP_SEEN  = 2'd0,
    OP_LOST  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_SMOOTH  = 3'd0,
    REG_RATE_SMOOTH = 3'd1,
    REG_DB_H        = 3'd2,
    REG_DB_V        = 3'd3,
    REG_GAIN_PAN    = 3'd4,
    REG_GAIN_TILT   = 3'd5,
    REG_ZONE_H      = 3'd6,
    REG_ZONE_V      = 3'd7
  } cfg_idx_t;

  // configuration as seen by the datapath (factors already clamped)
  typedef struct packed {
    logic [FAC_W-1:0]  pos_a;
    logic [FAC_W-1:0]  rate_b;
    logic [FAC_W-1:0]  rate_decay;
    logic [PIX_W-1:0]  db_h;
    logic [PIX_W-1:0]  db_v;
    logic [GAIN_W-1:0] gain_h;
    logic [GAIN_W-1:0] gain_v;
    logic [PIX_W-1:0]  zone_h;
    logic [PIX_W-1:0]  zone_v;
  } cfg_t;

  // small-width alu operations, both axes at once
  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_PDIFF,
    ALU_SEED,
    ALU_ERR,
    ALU_EXCESS,
    ALU_ZONE,
    ALU_RDIFF,
    ALU_CLRPOS,
    ALU_CLRALL
  } alu_t;

  // multiplier operand a
  typedef enum logic [2:0] {
    MA_POS,
    MA_RATE,
    MA_DECAY,
    MA_GAIN_H,
    MA_GAIN_V
  } ma_t;

  // multiplier operand b
  typedef enum logic [2:0] {
    MB_DX,
    MB_DY,
    MB_EXC_X,
    MB_EXC_Y,
    MB_PAN,
    MB_TILT
  } mb_t;

  // product write-back
  typedef enum logic [3:0] {
    WB_NONE,
    WB_SX,
    WB_SY,
    WB_TGT_X,
    WB_TGT_Y,
    WB_PAN_ADD,
    WB_TILT_ADD,
    WB_PAN_SET,
    WB_TILT_SET
  } wb_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_DONE
  } br_t;

  typedef struct packed {
    alu_t              alu;
    ma_t               ma;
    mb_t               mb;
    wb_t               wb;
    br_t               br;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef enum logic {
    SQ_IDLE,
    SQ_RUN
  } seq_state_t;

  // program addresses
  localparam logic [STEP_W-1:0] ST_DISPATCH  = STEP_W'(0);
  localparam logic [STEP_W-1:0] ST_POS_MUL_X = STEP_W'(1);
  localparam logic [STEP_W-1:0] ST_POS_MUL_Y = STEP_W'(2);
  localparam logic [STEP_W-1:0] ST_POS_WB_Y  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ST_ERR       = STEP_W'(4);
  localparam logic [STEP_W-1:0] ST_EXCESS    = STEP_W'(5);
  localparam logic [STEP_W-1:0] ST_GAIN_X    = STEP_W'(6);
  localparam logic [STEP_W-1:0] ST_GAIN_Y    = STEP_W'(7);
  localparam logic [STEP_W-1:0] ST_TGT_Y     = STEP_W'(8);
  localparam logic [STEP_W-1:0] ST_RDIFF     = STEP_W'(9);
  localparam logic [STEP_W-1:0] ST_RATE_X    = STEP_W'(10);
  localparam logic [STEP_W-1:0] ST_RATE_Y    = STEP_W'(11);
  localparam logic [STEP_W-1:0] ST_RATE_WB   = STEP_W'(12);
  localparam logic [STEP_W-1:0] ST_DONE      = STEP_W'(13);
  localparam logic [STEP_W-1:0] ST_SEED      = STEP_W'(14);
  localparam logic [STEP_W-1:0] ST_DECAY_X   = STEP_W'(15);
  localparam logic [STEP_W-1:0] ST_DECAY_Y   = STEP_W'(16);
  localparam logic [STEP_W-1:0] ST_DECAY_WB  = STEP_W'(17);
  localparam logic [STEP_W-1:0] ST_CLEAR     = STEP_W'(18);

  localparam ctrl_t CTRL_NOP = '{
    alu:    ALU_NONE,
    ma:     MA_POS,
    mb:     MB_DX,
    wb:     WB_NONE,
    br:     BR_NEXT,
    target: ST_DISPATCH
  };

  // control store: one word per program step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (step)
      ST_DISPATCH: begin
        w.alu = ALU_PDIFF;
        w.br  = BR_DISPATCH;
      end
      ST_POS_MUL_X: begin
        w.ma = MA_POS;
        w.mb = MB_DX;
      end
      ST_POS_MUL_Y: begin
        w.ma = MA_POS;
        w.mb = MB_DY;
        w.wb = WB_SX;
      end
      ST_POS_WB_Y: begin
        w.wb = WB_SY;
      end
      ST_ERR: begin
        w.alu = ALU_ERR;
      end
      ST_EXCESS: begin
        w.alu = ALU_EXCESS;
      end
      ST_GAIN_X: begin
        w.alu = ALU_ZONE;
        w.ma  = MA_GAIN_H;
        w.mb  = MB_EXC_X;
      end
      ST_GAIN_Y: begin
        w.ma = MA_GAIN_V;
        w.mb = MB_EXC_Y;
        w.wb = WB_TGT_X;
      end
      ST_TGT_Y: begin
        w.wb = WB_TGT_Y;
      end
      ST_RDIFF: begin
        w.alu = ALU_RDIFF;
      end
      ST_RATE_X: begin
        w.ma = MA_RATE;
        w.mb = MB_DX;
      end
      ST_RATE_Y: begin
        w.ma = MA_RATE;
        w.mb = MB_DY;
        w.wb = WB_PAN_ADD;
      end
      ST_RATE_WB: begin
        w.wb = WB_TILT_ADD;
      end
      ST_DONE: begin
        w.br = BR_DONE;
      end
      ST_SEED: begin
        w.alu    = ALU_SEED;
        w.br     = BR_JUMP;
        w.target = ST_ERR;
      end
      ST_DECAY_X: begin
        w.ma = MA_DECAY;
        w.mb = MB_PAN;
      end
      ST_DECAY_Y: begin
        w.ma = MA_DECAY;
        w.mb = MB_TILT;
        w.wb = WB_PAN_SET;
      end
      ST_DECAY_WB: begin
        w.alu    = ALU_CLRPOS;
        w.wb     = WB_TILT_SET;
        w.br     = BR_JUMP;
        w.target = ST_DONE;
      end
      ST_CLEAR: begin
        w.alu    = ALU_CLRALL;
        w.br     = BR_JUMP;
        w.target = ST_DONE;
      end
      default: begin
        w.br = BR_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/ptc_chan_if.sv
`default_nettype none

// request channel: one controller operation
interface ptc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptc_pkg::OP_W-1:0]      op;
  logic [ptc_pkg::PIX_W-1:0]     target_x;
  logic [ptc_pkg::PIX_W-1:0]     target_y;
  logic [ptc_pkg::PIX_W-1:0]     centre_x;
  logic [ptc_pkg::PIX_W-1:0]     centre_y;

  modport source (output valid, op, target_x, target_y, centre_x, centre_y, input ready);
  modport sink   (input valid, op, target_x, target_y, centre_x, centre_y, output ready);
endinterface

// result channel: smoothed drive rates
interface ptc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ptc_pkg::OUT_W-1:0] pan_rate;
  logic signed [ptc_pkg::OUT_W-1:0] tilt_rate;

  modport source (output valid, pan_rate, tilt_rate, input ready);
  modport sink   (input valid, pan_rate, tilt_rate, output ready);
endinterface

`default_nettype wire

FILE: src/ptc_seq.sv
`default_nettype none

module ptc_seq (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  ptc_pkg::op_t                 op,
  input  wire                          pos_valid,
  input  wire                          out_free,
  output ptc_pkg::ctrl_t               ctrl,
  output logic                         idle,
  output logic                         done
);

  ptc_pkg::seq_state_t           state_r, state_nxt;
  logic [ptc_pkg::STEP_W-1:0]    step_r, step_nxt;
  ptc_pkg::ctrl_t                word;

  // control store read
  assign word = ptc_pkg::ucode(step_r);

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptc_pkg::SQ_IDLE;
      step_r  <= ptc_pkg::ST_DISPATCH;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // next state and step address
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ptc_pkg::SQ_IDLE: begin
        if (start) begin
          state_nxt = ptc_pkg::SQ_RUN;
          step_nxt  = ptc_pkg::ST_DISPATCH;
        end
      end
      ptc_pkg::SQ_RUN: begin
        unique case (word.br)
          ptc_pkg::BR_NEXT: begin
            step_nxt = ptc_pkg::STEP_W'(step_r + 1'b1);
          end
          ptc_pkg::BR_JUMP: begin
            step_nxt = word.target;
          end
          ptc_pkg::BR_DISPATCH: begin
            case (op)
              ptc_pkg::OP_SEEN:  step_nxt = pos_valid ? ptc_pkg::ST_POS_MUL_X
                                                      : ptc_pkg::ST_SEED;
              ptc_pkg::OP_LOST:  step_nxt = ptc_pkg::ST_DECAY_X;
              ptc_pkg::OP_CLEAR: step_nxt = ptc_pkg::ST_CLEAR;
              default:           step_nxt = ptc_pkg::ST_DONE;
            endcase
          end
          ptc_pkg::BR_DONE: begin
            if (out_free) begin
              state_nxt = ptc_pkg::SQ_IDLE;
            end
          end
          default: begin
            state_nxt = ptc_pkg::SQ_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ptc_pkg::SQ_IDLE;
      end
    endcase
  end

  // outputs: control word only while running
  always_comb begin
    ctrl = ptc_pkg::CTRL_NOP;
    idle = 1'b0;
    done = 1'b0;
    unique case (state_r)
      ptc_pkg::SQ_IDLE: begin
        idle = 1'b1;
      end
      ptc_pkg::SQ_RUN: begin
        ctrl = word;
        done = (word.br == ptc_pkg::BR_DONE) && out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/ptc_dp.sv
`default_nettype none

module ptc_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  ptc_pkg::ctrl_t                       ctrl,
  input  ptc_pkg::cfg_t                        cfg,
  input  wire                                  load,
  input  wire  [ptc_pkg::OP_W-1:0]             in_op,
  input  wire  [ptc_pkg::PIX_W-1:0]            in_tx,
  input  wire  [ptc_pkg::PIX_W-1:0]            in_ty,
  input  wire  [ptc_pkg::PIX_W-1:0]            in_cx,
  input  wire  [ptc_pkg::PIX_W-1:0]            in_cy,
  output ptc_pkg::op_t                         op_q,
  output logic                                 pos_valid,
  output logic signed [ptc_pkg::OUT_W-1:0]     pan_out,
  output logic signed [ptc_pkg::OUT_W-1:0]     tilt_out
);

  localparam int PW = ptc_pkg::PROD_W;
  localparam int SW = ptc_pkg::PROD_W + ptc_pkg::SLOW_W;

  // target rate from gain product: scale, clamp, deadband, sign
  function automatic logic signed [ptc_pkg::TGT_W-1:0] tgt_rate(
    input logic [PW-1:0] p,
    input logic          slow,
    input logic          dead,
    input logic          neg
  );
    logic [SW-1:0]               scaled;
    logic [SW-1:0]               mag;
    logic [ptc_pkg::TGT_W-1:0]   lim;
    scaled = SW'(p) * SW'(ptc_pkg::SLOW_SCALE_Q8);
    if (slow) begin
      mag = scaled >> 16;
    end else begin
      mag = SW'(p) >> 8;
    end
    if (mag > SW'(ptc_pkg::MAX_DRIVE_RATE)) begin
      lim = ptc_pkg::TGT_W'(ptc_pkg::MAX_DRIVE_RATE);
    end else begin
      lim = mag[ptc_pkg::TGT_W-1:0];
    end
    if (dead) begin
      return '0;
    end
    return neg ? $signed(-lim) : $signed(lim);
  endfunction

  // item registers
  logic [ptc_pkg::OP_W-1:0]   op_r;
  logic [ptc_pkg::PIX_W-1:0]  tx_r, ty_r, cx_r, cy_r;

  // architectural state
  logic                              valid_r, valid_nxt;
  logic [ptc_pkg::POS_W-1:0]         sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [ptc_pkg::RATE_W-1:0] pan_r, pan_nxt, tilt_r, tilt_nxt;

  // scratch registers
  logic signed [ptc_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [ptc_pkg::ERR_W-1:0]  ex_r, ex_nxt, ey_r, ey_nxt;
  logic [ptc_pkg::PIX_W-1:0]         exc_x_r, exc_x_nxt, exc_y_r, exc_y_nxt;
  logic                              dead_x_r, dead_x_nxt, dead_y_r, dead_y_nxt;
  logic                              neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic                              slow_x_r, slow_x_nxt, slow_y_r, slow_y_nxt;
  logic signed [ptc_pkg::TGT_W-1:0]  tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic signed [PW-1:0]              prod_r, prod_nxt;

  // multiplier operands and helpers
  logic signed [ptc_pkg::MA_W-1:0]   a_op;
  logic signed [ptc_pkg::DIFF_W-1:0] b_op;
  logic signed [PW-1:0]              prod_bias, prod_t8;
  logic signed [PW-1:0]              sx_sum, sy_sum, pan_sum, tilt_sum;
  logic signed [ptc_pkg::ERR_W-1:0]  mag_x, mag_y;
  logic signed [ptc_pkg::RATE_W-1:0] pan_bias, tilt_bias;

  assign op_q      = ptc_pkg::op_t'(op_r);
  assign pos_valid = valid_r;

  // product truncated toward zero after the q8 shift
  assign prod_bias = prod_r + $signed({{(PW-8){1'b0}}, {8{prod_r[PW-1]}}});
  assign prod_t8   = {{8{prod_bias[PW-1]}}, prod_bias[PW-1:8]};

  assign sx_sum   = $signed({1'b0, sx_r}) + prod_t8;
  assign sy_sum   = $signed({1'b0, sy_r}) + prod_t8;
  assign pan_sum  = pan_r + prod_t8;
  assign tilt_sum = tilt_r + prod_t8;

  assign mag_x = ex_r[ptc_pkg::ERR_W-1] ? -ex_r : ex_r;
  assign mag_y = ey_r[ptc_pkg::ERR_W-1] ? -ey_r : ey_r;

  // emitted integer rate, truncated toward zero
  assign pan_bias  = pan_r + $signed({{(ptc_pkg::RATE_W-8){1'b0}}, {8{pan_r[ptc_pkg::RATE_W-1]}}});
  assign tilt_bias = tilt_r + $signed({{(ptc_pkg::RATE_W-8){1'b0}},
                                       {8{tilt_r[ptc_pkg::RATE_W-1]}}});
  assign pan_out   = pan_bias[ptc_pkg::RATE_W-1:8];
  assign tilt_out  = tilt_bias[ptc_pkg::RATE_W-1:8];

  // multiplier operand select
  always_comb begin
    case (ctrl.ma)
      ptc_pkg::MA_POS:    a_op = $signed({{(ptc_pkg::MA_W-ptc_pkg::FAC_W){1'b0}}, cfg.pos_a});
      ptc_pkg::MA_RATE:   a_op = $signed({{(ptc_pkg::MA_W-ptc_pkg::FAC_W){1'b0}}, cfg.rate_b});
      ptc_pkg::MA_DECAY:  a_op = $signed({{(ptc_pkg::MA_W-ptc_pkg::FAC_W){1'b0}},
                                          cfg.rate_decay});
      ptc_pkg::MA_GAIN_H: a_op = $signed({{(ptc_pkg::MA_W-ptc_pkg::GAIN_W){1'b0}}, cfg.gain_h});
      ptc_pkg::MA_GAIN_V: a_op = $signed({{(ptc_pkg::MA_W-ptc_pkg::GAIN_W){1'b0}}, cfg.gain_v});
      default:            a_op = '0;
    endcase
    case (ctrl.mb)
      ptc_pkg::MB_DX:    b_op = dx_r;
      ptc_pkg::MB_DY:    b_op = dy_r;
      ptc_pkg::MB_EXC_X: b_op = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::PIX_W){1'b0}}, exc_x_r});
      ptc_pkg::MB_EXC_Y: b_op = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::PIX_W){1'b0}}, exc_y_r});
      ptc_pkg::MB_PAN:   b_op = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::RATE_W){pan_r[ptc_pkg::RATE_W-1]}},
                                         pan_r});
      ptc_pkg::MB_TILT:  b_op = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::RATE_W){tilt_r[ptc_pkg::RATE_W-1]}},
                                         tilt_r});
      default:           b_op = '0;
    endcase
    prod_nxt = a_op * b_op;
  end

  // alu and write-back
  always_comb begin
    valid_nxt  = valid_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    pan_nxt    = pan_r;
    tilt_nxt   = tilt_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    exc_x_nxt  = exc_x_r;
    exc_y_nxt  = exc_y_r;
    dead_x_nxt = dead_x_r;
    dead_y_nxt = dead_y_r;
    neg_x_nxt  = neg_x_r;
    neg_y_nxt  = neg_y_r;
    slow_x_nxt = slow_x_r;
    slow_y_nxt = slow_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;

    case (ctrl.alu)
      // distance from smoothed position to new sighting
      ptc_pkg::ALU_PDIFF: begin
        dx_nxt = $signed({1'b0, tx_r, 8'b0}) - $signed({1'b0, sx_r});
        dy_nxt = $signed({1'b0, ty_r, 8'b0}) - $signed({1'b0, sy_r});
      end
      // first sighting seeds the position
      ptc_pkg::ALU_SEED: begin
        sx_nxt    = {tx_r, 8'b0};
        sy_nxt    = {ty_r, 8'b0};
        valid_nxt = 1'b1;
      end
      // pixel error, vertical axis negated
      ptc_pkg::ALU_ERR: begin
        ex_nxt = $signed({1'b0, sx_r[ptc_pkg::POS_W-1:8]}) - $signed({1'b0, cx_r});
        ey_nxt = $signed({1'b0, cy_r}) - $signed({1'b0, sy_r[ptc_pkg::POS_W-1:8]});
      end
      // magnitude beyond the deadband
      ptc_pkg::ALU_EXCESS: begin
        dead_x_nxt = mag_x[ptc_pkg::PIX_W-1:0] <= cfg.db_h;
        dead_y_nxt = mag_y[ptc_pkg::PIX_W-1:0] <= cfg.db_v;
        exc_x_nxt  = mag_x[ptc_pkg::PIX_W-1:0] - cfg.db_h;
        exc_y_nxt  = mag_y[ptc_pkg::PIX_W-1:0] - cfg.db_v;
        neg_x_nxt  = ex_r[ptc_pkg::ERR_W-1];
        neg_y_nxt  = ey_r[ptc_pkg::ERR_W-1];
      end
      ptc_pkg::ALU_ZONE: begin
        slow_x_nxt = exc_x_r <= cfg.zone_h;
        slow_y_nxt = exc_y_r <= cfg.zone_v;
      end
      // target rate minus current rate, q8
      ptc_pkg::ALU_RDIFF: begin
        dx_nxt = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::TGT_W-8){tgt_x_r[ptc_pkg::TGT_W-1]}},
                          tgt_x_r, 8'b0})
               - $signed({{(ptc_pkg::DIFF_W-ptc_pkg::RATE_W){pan_r[ptc_pkg::RATE_W-1]}}, pan_r});
        dy_nxt = $signed({{(ptc_pkg::DIFF_W-ptc_pkg::TGT_W-8){tgt_y_r[ptc_pkg::TGT_W-1]}},
                          tgt_y_r, 8'b0})
               - $signed({{(ptc_pkg::DIFF_W-ptc_pkg::RATE_W){tilt_r[ptc_pkg::RATE_W-1]}},
                          tilt_r});
      end
      ptc_pkg::ALU_CLRPOS: begin
        valid_nxt = 1'b0;
        sx_nxt    = '0;
        sy_nxt    = '0;
      end
      ptc_pkg::ALU_CLRALL: begin
        valid_nxt = 1'b0;
        sx_nxt    = '0;
        sy_nxt    = '0;
        pan_nxt   = '0;
        tilt_nxt  = '0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase

    case (ctrl.wb)
      ptc_pkg::WB_SX:       sx_nxt    = sx_sum[ptc_pkg::POS_W-1:0];
      ptc_pkg::WB_SY:       sy_nxt    = sy_sum[ptc_pkg::POS_W-1:0];
      ptc_pkg::WB_TGT_X:    tgt_x_nxt = tgt_rate($unsigned(prod_r), slow_x_r, dead_x_r, neg_x_r);
      ptc_pkg::WB_TGT_Y:    tgt_y_nxt = tgt_rate($unsigned(prod_r), slow_y_r, dead_y_r, neg_y_r);
      ptc_pkg::WB_PAN_ADD:  pan_nxt   = pan_sum[ptc_pkg::RATE_W-1:0];
      ptc_pkg::WB_TILT_ADD: tilt_nxt  = tilt_sum[ptc_pkg::RATE_W-1:0];
      ptc_pkg::WB_PAN_SET:  pan_nxt   = prod_t8[ptc_pkg::RATE_W-1:0];
      ptc_pkg::WB_TILT_SET: tilt_nxt  = prod_t8[ptc_pkg::RATE_W-1:0];
      default:              tgt_x_nxt = tgt_x_nxt;
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      pan_r   <= '0;
      tilt_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      pan_r   <= pan_nxt;
      tilt_r  <= tilt_nxt;
    end
  end

  // request capture and scratch registers
  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_op;
      tx_r <= in_tx;
      ty_r <= in_ty;
      cx_r <= in_cx;
      cy_r <= in_cy;
    end
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    ex_r     <= ex_nxt;
    ey_r     <= ey_nxt;
    exc_x_r  <= exc_x_nxt;
    exc_y_r  <= exc_y_nxt;
    dead_x_r <= dead_x_nxt;
    dead_y_r <= dead_y_nxt;
    neg_x_r  <= neg_x_nxt;
    neg_y_r  <= neg_y_nxt;
    slow_x_r <= slow_x_nxt;
    slow_y_r <= slow_y_nxt;
    tgt_x_r  <= tgt_x_nxt;
    tgt_y_r  <= tgt_y_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

`default_nettype wire

FILE: src/pan_tilt_tracking_rate_controller_core.sv
// Two-axis pan/tilt tracking rate controller with deadband and smoothing.
// in_chan: valid/ready request carrying op, target_x/y and centre_x/y.
//   op seen smooths or seeds the target position and updates both drive rates,
//   op lost decays the rates and forgets the position, op clear zeroes all
//   state; the fourth code only reports the current rates.
// out_chan: valid/ready result carrying signed pan_rate and tilt_rate,
//   one result per request, in request order.
// cfg_we/cfg_index/cfg_data: register write, applied at the clock edge
//   with cfg_we high; write only while no request is in flight.
// Request-to-result time depends on the op: longest for a sighting with a
// known position, then a first sighting, a loss, a clear and a report.
// One request is in work at a time; in_chan.ready is high whenever the
// microcode sequencer is idle, which it becomes at the edge that loads
// the result. The time per request is set by the program length, with one
// shared 17x21 multiplier.
// A stalled result is held in the output register; the sequencer waits on
// its final step until that register can be reloaded.
// rst_n (synchronous) restores register defaults and clears position and
// rate state; no result is pending after reset.
`default_nettype none

module pan_tilt_tracking_rate_controller_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  ptc_in_if.sink                              in_chan,
  ptc_out_if.source                           out_chan,
  input  wire                                 cfg_we,
  input  wire  [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ptc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // factors above one act as one
  function automatic logic [ptc_pkg::FAC_W-1:0] clamp_fac(input logic [ptc_pkg::FAC_W-1:0] v);
    if (v > ptc_pkg::FAC_W'(ptc_pkg::FAC_ONE)) begin
      return ptc_pkg::FAC_W'(ptc_pkg::FAC_ONE);
    end
    return v;
  endfunction

  ptc_pkg::cfg_t                     cfg_r, cfg_nxt;
  ptc_pkg::ctrl_t                    ctrl;
  ptc_pkg::op_t                      op_q;
  logic                              pos_valid;
  logic                              seq_idle;
  logic                              seq_done;
  logic                              accept;
  logic                              out_free;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [ptc_pkg::OUT_W-1:0]  pan_dp, tilt_dp;
  logic signed [ptc_pkg::OUT_W-1:0]  pan_r, tilt_r;
  logic [ptc_pkg::FAC_W-1:0]         wr_fac;

  assign in_chan.ready = seq_idle;
  assign accept        = in_chan.valid && seq_idle;
  assign out_free      = !out_valid_r || out_chan.ready;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    wr_fac  = clamp_fac(cfg_data[ptc_pkg::FAC_W-1:0]);
    if (cfg_we) begin
      unique case (ptc_pkg::cfg_idx_t'(cfg_index))
        ptc_pkg::REG_POS_SMOOTH:  cfg_nxt.pos_a  = wr_fac;
        ptc_pkg::REG_RATE_SMOOTH: begin
          cfg_nxt.rate_b     = wr_fac;
          cfg_nxt.rate_decay = ptc_pkg::FAC_W'(ptc_pkg::FAC_ONE) - wr_fac;
        end
        ptc_pkg::REG_DB_H:        cfg_nxt.db_h   = cfg_data[ptc_pkg::PIX_W-1:0];
        ptc_pkg::REG_DB_V:        cfg_nxt.db_v   = cfg_data[ptc_pkg::PIX_W-1:0];
        ptc_pkg::REG_GAIN_PAN:    cfg_nxt.gain_h = cfg_data[ptc_pkg::GAIN_W-1:0];
        ptc_pkg::REG_GAIN_TILT:   cfg_nxt.gain_v = cfg_data[ptc_pkg::GAIN_W-1:0];
        ptc_pkg::REG_ZONE_H:      cfg_nxt.zone_h = cfg_data[ptc_pkg::PIX_W-1:0];
        ptc_pkg::REG_ZONE_V:      cfg_nxt.zone_v = cfg_data[ptc_pkg::PIX_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_a      <= ptc_pkg::RST_POS_SMOOTH;
      cfg_r.rate_b     <= ptc_pkg::RST_RATE_SMOOTH;
      cfg_r.rate_decay <= ptc_pkg::FAC_W'(ptc_pkg::FAC_ONE) - ptc_pkg::RST_RATE_SMOOTH;
      cfg_r.db_h       <= ptc_pkg::RST_DEADBAND;
      cfg_r.db_v       <= ptc_pkg::RST_DEADBAND;
      cfg_r.gain_h     <= ptc_pkg::RST_GAIN;
      cfg_r.gain_v     <= ptc_pkg::RST_GAIN;
      cfg_r.zone_h     <= ptc_pkg::RST_SLOW_ZONE;
      cfg_r.zone_v     <= ptc_pkg::RST_SLOW_ZONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // microcode sequencer
  ptc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .op        (op_q),
    .pos_valid (pos_valid),
    .out_free  (out_free),
    .ctrl      (ctrl),
    .idle      (seq_idle),
    .done      (seq_done)
  );

  // datapath with the shared multiplier
  ptc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cfg       (cfg_r),
    .load      (accept),
    .in_op     (in_chan.op),
    .in_tx     (in_chan.target_x),
    .in_ty     (in_chan.target_y),
    .in_cx     (in_chan.centre_x),
    .in_cy     (in_chan.centre_y),
    .op_q      (op_q),
    .pos_valid (pos_valid),
    .pan_out   (pan_dp),
    .tilt_out  (tilt_dp)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      pan_r  <= pan_dp;
      tilt_r <= tilt_dp;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.pan_rate  = pan_r;
  assign out_chan.tilt_rate = tilt_r;

endmodule

`default_nettype wire

FILE: src/ptc_chk.sv
`default_nettype none
`include "assert_macros.svh"

module ptc_chk (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_ready,
  input wire                             out_valid,
  input wire                             out_ready,
  input wire [ptc_pkg::OUT_W-1:0]        pan_rate,
  input wire [ptc_pkg::OUT_W-1:0]        tilt_rate
);

  localparam logic [ptc_pkg::OUT_W-1:0] RATE_MOST_NEG = {1'b1, {(ptc_pkg::OUT_W-1){1'b0}}};

  // a waiting result is not dropped
  `PTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // one request in work at a time
  `PTC_ASSERT_NEXT(a_busy_after_req, rst_n && in_valid && in_ready, !in_ready)

  // rates stay within the clamp, never the most negative code
  `PTC_ASSERT_SAME(a_rate_range, out_valid, pan_rate != RATE_MOST_NEG && tilt_rate != RATE_MOST_NEG)

  // no result appears in the cycle right after a request is taken
  `PTC_ASSERT_SAME(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind pan_tilt_tracking_rate_controller_core ptc_chk u_ptc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pan_rate  (out_chan.pan_rate),
  .tilt_rate (out_chan.tilt_rate)
);

`default_nettype wire
